[sv/rpnfx_pkg.sv]
package rpnfx_pkg;

  // Defaults for the top-level parameters
  localparam int STACK_DEPTH_DEF     = 256;
  localparam int FRACTION_DIGITS_DEF = 3;

  // Fixed field widths
  localparam int VALUE_W = 32;
  localparam int REQ_W   = 3;
  localparam int DEPTH_W = 9;
  localparam int PROD_W  = 64;

  // Request codes on the input port
  localparam logic [REQ_W-1:0] REQ_PUSH  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_ADD   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_SUB   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_MUL   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DIV   = 3'd4;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd5;

  // Classified command kinds passed from front to back
  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_CLEAR,
    CMD_PUSH,
    CMD_ADD,
    CMD_SUB,
    CMD_MUL,
    CMD_DIV
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                   kind;
    logic                        carry;
    logic signed [VALUE_W-1:0]   number;
  } cmd_t;

  // Divider request and response
  typedef struct packed {
    logic                        start;
    logic signed [PROD_W-1:0]    dividend;
    logic signed [VALUE_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic                        done;
    logic signed [VALUE_W-1:0]   quotient;
  } div_rsp_t;

  // Decimal scale factor 10^n, evaluated at elaboration
  function automatic int pow10(input int n);
    int s;
    s = 1;
    for (int i = 0; i < n; i++) begin
      s = s * 10;
    end
    return s;
  endfunction

endpackage

[sv/rpnfx_front.sv]
module rpnfx_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  output logic                                  full,
  input  logic [rpnfx_pkg::REQ_W-1:0]           req_type,
  input  logic                                  carries_number,
  input  logic signed [rpnfx_pkg::VALUE_W-1:0]  number,
  output rpnfx_pkg::cmd_t                       cmd,
  output logic                                  cmd_valid,
  input  logic                                  cmd_pop
);
  import rpnfx_pkg::*;

  cmd_t       decoded;
  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       take_in;
  logic       take_out;

  // Classify the incoming item
  always_comb begin
    decoded.carry  = carries_number;
    decoded.number = number;
    case (req_type)
      REQ_PUSH:  decoded.kind = carries_number ? CMD_PUSH : CMD_NOP;
      REQ_ADD:   decoded.kind = CMD_ADD;
      REQ_SUB:   decoded.kind = CMD_SUB;
      REQ_MUL:   decoded.kind = CMD_MUL;
      REQ_DIV:   decoded.kind = CMD_DIV;
      REQ_CLEAR: decoded.kind = CMD_CLEAR;
      default:   decoded.kind = CMD_NOP;
    endcase
  end

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = slots[rd_ptr];
  assign take_in   = push && !full;
  assign take_out  = cmd_pop && cmd_valid;

  // Store classified commands
  always_ff @(posedge clk) begin
    if (take_in) begin
      slots[wr_ptr] <= decoded;
    end
  end

  // Advance queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (take_in) begin
        wr_ptr <= ~wr_ptr;
      end
      if (take_out) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({take_in, take_out})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[sv/rpnfx_div.sv]
module rpnfx_div (
  input  logic                clk,
  input  logic                rst,
  input  rpnfx_pkg::div_req_t req,
  output rpnfx_pkg::div_rsp_t rsp
);
  import rpnfx_pkg::*;

  localparam int STEP_W = $clog2(PROD_W);

  logic                 busy;
  logic                 done;
  logic [STEP_W-1:0]    step;
  logic [VALUE_W-1:0]   rem;
  logic [PROD_W-1:0]    quo;
  logic [VALUE_W-1:0]   dvs;
  logic                 neg;
  logic [VALUE_W:0]     trial;
  logic [VALUE_W:0]     diff;
  logic                 fits;

  // One restoring step: shift in the next dividend bit and try to subtract
  assign trial = {rem, quo[PROD_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      // Flag completion on the edge that takes the last step
      done <= busy && (step == '0);
      if (busy) begin
        rem <= fits ? diff[VALUE_W-1:0] : trial[VALUE_W-1:0];
        quo <= {quo[PROD_W-2:0], fits};
        if (step == '0) begin
          busy <= 1'b0;
        end else begin
          step <= step - 1'b1;
        end
      end else if (req.start) begin
        // Load magnitudes; the quotient sign is applied on the way out
        busy <= 1'b1;
        step <= STEP_W'(PROD_W - 1);
        rem  <= '0;
        quo  <= req.dividend[PROD_W-1] ? PROD_W'(-req.dividend) : PROD_W'(req.dividend);
        dvs  <= req.divisor[VALUE_W-1] ? VALUE_W'(-req.divisor) : VALUE_W'(req.divisor);
        neg  <= req.dividend[PROD_W-1] ^ req.divisor[VALUE_W-1];
      end
    end
  end

  // Truncate toward zero: negate the magnitude quotient, keep the low word
  assign rsp.done     = done;
  assign rsp.quotient = neg ? VALUE_W'(-quo[VALUE_W-1:0]) : quo[VALUE_W-1:0];

endmodule

[sv/rpnfx_back.sv]
module rpnfx_back #(
  parameter int STACK_DEPTH     = rpnfx_pkg::STACK_DEPTH_DEF,
  parameter int FRACTION_DIGITS = rpnfx_pkg::FRACTION_DIGITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  rpnfx_pkg::cmd_t                       cmd,
  input  logic                                  cmd_valid,
  output logic                                  cmd_pop,
  output rpnfx_pkg::div_req_t                   div_req,
  input  rpnfx_pkg::div_rsp_t                   div_rsp,
  output logic signed [rpnfx_pkg::VALUE_W-1:0]  top_value,
  output logic [rpnfx_pkg::DEPTH_W-1:0]         stack_depth,
  output logic                                  error,
  output logic                                  empty,
  input  logic                                  pop
);
  import rpnfx_pkg::*;

  localparam int AW    = $clog2(STACK_DEPTH);
  localparam int DW    = $clog2(STACK_DEPTH + 1);
  localparam int EXT_W = DW + DEPTH_W;
  localparam logic [DW-1:0] FULL_DEPTH = DW'(STACK_DEPTH);
  localparam logic signed [VALUE_W-1:0] SCALE = VALUE_W'(pow10(FRACTION_DIGITS));

  typedef enum logic [3:0] {
    S_IDLE,
    S_POP_A,
    S_GET_A,
    S_POP_B,
    S_GET_B,
    S_CALC,
    S_DIV_GO,
    S_DIV_WAIT,
    S_PUSH,
    S_READ_TOP,
    S_OUT
  } state_t;

  state_t                     state;
  cmd_t                       cur;
  logic [DW-1:0]              depth;
  logic [DW-1:0]              depth_m1;
  logic [DW-1:0]              restart_depth;
  logic [EXT_W-1:0]           depth_ext;
  logic signed [VALUE_W-1:0]  last_answer;
  logic signed [VALUE_W-1:0]  a_val;
  logic signed [VALUE_W-1:0]  b_val;
  logic signed [VALUE_W-1:0]  res;
  logic signed [VALUE_W-1:0]  mul_opnd;
  logic signed [PROD_W-1:0]   product;
  logic signed [PROD_W-1:0]   prod;
  logic                       fault;
  logic                       err_flag;
  logic                       out_valid;

  logic [VALUE_W-1:0]         mem [STACK_DEPTH];
  logic [VALUE_W-1:0]         rd_data;
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [VALUE_W-1:0]         mem_wdata;

  assign depth_m1      = depth - 1'b1;
  assign restart_depth = DW'(last_answer != '0);
  assign depth_ext     = EXT_W'(depth);
  assign empty         = !out_valid;
  assign cmd_pop       = (state == S_IDLE) && cmd_valid;

  // Shared multiplier: operand times second value, or times the scale for divide
  assign mul_opnd = (cur.kind == CMD_DIV) ? SCALE : b_val;
  assign product  = a_val * mul_opnd;

  // Divider request
  assign div_req.start    = (state == S_DIV_GO);
  assign div_req.dividend = prod;
  assign div_req.divisor  = (cur.kind == CMD_DIV) ? b_val : SCALE;

  // Stack write port: push of a value, or restart with the last answer at entry zero
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = depth[AW-1:0];
    mem_wdata = res;
    case (state)
      S_IDLE: begin
        if (cmd_valid && cmd.kind == CMD_PUSH) begin
          mem_we = 1'b1;
          if (depth == FULL_DEPTH) begin
            mem_waddr = '0;
            mem_wdata = last_answer;
          end else begin
            mem_wdata = cmd.number;
          end
        end
      end
      S_PUSH: begin
        mem_we = 1'b1;
        if (fault) begin
          mem_waddr = '0;
          mem_wdata = last_answer;
        end
      end
      default: mem_we = 1'b0;
    endcase
  end

  // Stack memory; the read port always follows the top entry
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[depth_m1[AW-1:0]];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      depth       <= '0;
      last_answer <= '0;
      out_valid   <= 1'b0;
    end else begin
      // Drop a taken result unless a new one replaces it in the same cycle
      if (pop && out_valid && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cur   <= cmd;
            fault <= 1'b0;
            case (cmd.kind)
              CMD_CLEAR: begin
                depth    <= '0;
                err_flag <= 1'b0;
                state    <= S_READ_TOP;
              end
              CMD_PUSH: begin
                if (depth == FULL_DEPTH) begin
                  depth    <= restart_depth;
                  err_flag <= 1'b1;
                end else begin
                  depth    <= depth + 1'b1;
                  err_flag <= 1'b0;
                end
                state <= S_READ_TOP;
              end
              CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
                state <= S_POP_A;
              end
              default: begin
                err_flag <= 1'b0;
                state    <= S_READ_TOP;
              end
            endcase
          end
        end
        S_POP_A: begin
          // Pop of an empty stack yields one
          if (depth == '0) begin
            a_val       <= VALUE_W'(1);
            last_answer <= VALUE_W'(1);
            fault       <= 1'b1;
            state       <= S_POP_B;
          end else begin
            depth <= depth_m1;
            state <= S_GET_A;
          end
        end
        S_GET_A: begin
          a_val       <= rd_data;
          last_answer <= rd_data;
          state       <= S_POP_B;
        end
        S_POP_B: begin
          // A carried number is pushed and popped straight back
          if (cur.carry) begin
            b_val <= cur.number;
            state <= S_CALC;
          end else if (depth == '0) begin
            b_val <= VALUE_W'(1);
            fault <= 1'b1;
            state <= S_CALC;
          end else begin
            depth <= depth_m1;
            state <= S_GET_B;
          end
        end
        S_GET_B: begin
          b_val <= rd_data;
          state <= S_CALC;
        end
        S_CALC: begin
          case (cur.kind)
            CMD_ADD: begin
              res   <= a_val + b_val;
              state <= S_PUSH;
            end
            CMD_SUB: begin
              res   <= a_val - b_val;
              state <= S_PUSH;
            end
            CMD_MUL: begin
              prod  <= product;
              state <= S_DIV_GO;
            end
            CMD_DIV: begin
              if (b_val == '0) begin
                fault <= 1'b1;
                state <= S_PUSH;
              end else begin
                prod  <= product;
                state <= S_DIV_GO;
              end
            end
            default: state <= S_PUSH;
          endcase
        end
        S_DIV_GO: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_rsp.done) begin
            res   <= div_rsp.quotient;
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (fault) begin
            depth    <= restart_depth;
            err_flag <= 1'b1;
          end else begin
            depth    <= depth + 1'b1;
            err_flag <= 1'b0;
          end
          state <= S_READ_TOP;
        end
        S_READ_TOP: begin
          state <= S_OUT;
        end
        S_OUT: begin
          // Hold until the result register is free
          if (!out_valid || pop) begin
            out_valid   <= 1'b1;
            top_value   <= (depth == '0) ? '0 : rd_data;
            stack_depth <= depth_ext[DEPTH_W-1:0];
            error       <= err_flag;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[sv/rpn_fixed_point_stack_alu.sv]
// Fixed-point RPN stack engine with decimal scale 10^FRACTION_DIGITS. Items enter through a
// two-entry command queue and results leave through a one-entry result register, each side
// with queue-style push/full and pop/empty handshakes, and every item gives exactly one
// result: top of stack (0 when empty), depth and an error flag. A push, clear or ignored
// request goes through the top read and the output state in the execution engine; add and
// subtract first take the two stack reads through the registered memory port; multiply and
// divide also wait on the shared radix-2 divider that takes 64 steps per item. Stack memory
// needs no clearing pass after reset, so items are taken from the first cycle.
module rpn_fixed_point_stack_alu #(
  parameter int STACK_DEPTH     = rpnfx_pkg::STACK_DEPTH_DEF,
  parameter int FRACTION_DIGITS = rpnfx_pkg::FRACTION_DIGITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  output logic                                  full,
  input  logic [rpnfx_pkg::REQ_W-1:0]           req_type,
  input  logic                                  carries_number,
  input  logic signed [rpnfx_pkg::VALUE_W-1:0]  number,
  output logic                                  empty,
  input  logic                                  pop,
  output logic signed [rpnfx_pkg::VALUE_W-1:0]  top_value,
  output logic [rpnfx_pkg::DEPTH_W-1:0]         stack_depth,
  output logic                                  error
);
  import rpnfx_pkg::*;

  cmd_t     cmd;
  logic     cmd_valid;
  logic     cmd_pop;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // Accept and classify items
  rpnfx_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .req_type       (req_type),
    .carries_number (carries_number),
    .number         (number),
    .cmd            (cmd),
    .cmd_valid      (cmd_valid),
    .cmd_pop        (cmd_pop)
  );

  // Execute commands on the stack
  rpnfx_back #(
    .STACK_DEPTH     (STACK_DEPTH),
    .FRACTION_DIGITS (FRACTION_DIGITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cmd_valid   (cmd_valid),
    .cmd_pop     (cmd_pop),
    .div_req     (div_req),
    .div_rsp     (div_rsp),
    .top_value   (top_value),
    .stack_depth (stack_depth),
    .error       (error),
    .empty       (empty),
    .pop         (pop)
  );

  // Iterative divider for scaling products and quotients
  rpnfx_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // After an error the stack holds at most the last answer
  a_err_depth: assert property (@(posedge clk) disable iff (rst)
    (!empty && error) |-> (stack_depth == 9'd0 || stack_depth == 9'd1))
    else $error("error result with more than one entry");

  // A restarted stack of one entry holds a nonzero last answer
  a_err_top_one: assert property (@(posedge clk) disable iff (rst)
    (!empty && error && stack_depth == 9'd1) |-> (top_value != '0))
    else $error("restart kept a zero answer on the stack");

  // An empty restarted stack shows zero on top
  a_err_top_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && error && stack_depth == 9'd0) |-> (top_value == '0))
    else $error("empty restarted stack shows a nonzero top");

endmodule

[test/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rpnfx_pkg::*;

  localparam int STACK_N = 256;
  localparam int FRAC_DIGITS = 3;
  localparam logic signed [63:0] DECIMAL_SCALE = 64'sd1000;  // 10^FRAC_DIGITS
  localparam logic [REQ_W-1:0] REQ_UNUSED_A = 3'd6;
  localparam logic [REQ_W-1:0] REQ_UNUSED_B = 3'd7;
  localparam int IDLE_PCT = 29;
  localparam int ITEM_TARGET = 850;
  localparam int QUIET_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 100;

  typedef struct packed {
    logic signed [VALUE_W-1:0] top;
    logic [DEPTH_W-1:0]        depth;
    logic                      err;
  } outcome_t;

  typedef struct packed {
    logic [REQ_W-1:0]          rq;
    logic                      cn;
    logic signed [VALUE_W-1:0] nv;
    logic                      known;
    outcome_t                  want;
  } step_row_t;

  localparam outcome_t NO_RESULT = '0;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      push = 1'b0;
  logic                      full;
  logic [REQ_W-1:0]          req_type = '0;
  logic                      carries_number = 1'b0;
  logic signed [VALUE_W-1:0] number = '0;
  logic                      empty;
  logic                      pop = 1'b0;
  logic signed [VALUE_W-1:0] top_value;
  logic [DEPTH_W-1:0]        stack_depth;
  logic                      error;

  rpn_fixed_point_stack_alu #(
    .STACK_DEPTH    (STACK_N),
    .FRACTION_DIGITS(FRAC_DIGITS)
  ) uut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .req_type      (req_type),
    .carries_number(carries_number),
    .number        (number),
    .empty         (empty),
    .pop           (pop),
    .top_value     (top_value),
    .stack_depth   (stack_depth),
    .error         (error)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Directed sequence, walked from reset; typed results only where obvious
  step_row_t plan [25] = '{
    '{REQ_PUSH,     1'b0, 32'sd0,         1'b1, '{32'sd0, 9'd0, 1'b0}},
    '{REQ_SUB,      1'b0, 32'sd0,         1'b1, '{32'sd1, 9'd1, 1'b1}},
    '{REQ_CLEAR,    1'b1, 32'sd123,       1'b1, '{32'sd0, 9'd0, 1'b0}},
    '{REQ_PUSH,     1'b1, 32'sh7FFFFFFF,  1'b1, '{32'sh7FFFFFFF, 9'd1, 1'b0}},
    '{REQ_PUSH,     1'b1, 32'sh80000000,  1'b1, '{32'sh80000000, 9'd2, 1'b0}},
    '{REQ_ADD,      1'b0, 32'sd0,         1'b0, NO_RESULT},
    '{REQ_SUB,      1'b1, 32'sd5000,      1'b0, NO_RESULT},
    '{REQ_MUL,      1'b1, 32'sd2000,      1'b0, NO_RESULT},
    '{REQ_DIV,      1'b1, 32'sd0,         1'b1, '{-32'sd10002, 9'd1, 1'b1}},
    '{REQ_DIV,      1'b1, 32'sd3000,      1'b0, NO_RESULT},
    '{REQ_MUL,      1'b1, 32'sh7FFFFFFF,  1'b0, NO_RESULT},
    '{REQ_PUSH,     1'b1, 32'sh80000000,  1'b0, NO_RESULT},
    '{REQ_DIV,      1'b1, 32'shFFFFFFFF,  1'b0, NO_RESULT},
    '{REQ_MUL,      1'b1, 32'sh80000000,  1'b0, NO_RESULT},
    '{REQ_UNUSED_A, 1'b1, 32'sh12345678,  1'b0, NO_RESULT},
    '{REQ_UNUSED_B, 1'b0, 32'shEDCBA987,  1'b0, NO_RESULT},
    '{REQ_ADD,      1'b1, 32'sd1,         1'b0, NO_RESULT},
    '{REQ_CLEAR,    1'b0, 32'sd0,         1'b1, '{32'sd0, 9'd0, 1'b0}},
    '{REQ_DIV,      1'b0, 32'sd0,         1'b1, '{32'sd1, 9'd1, 1'b1}},
    '{REQ_MUL,      1'b1, 32'sd0,         1'b0, NO_RESULT},
    '{REQ_ADD,      1'b0, 32'sd0,         1'b1, '{32'sd0, 9'd0, 1'b1}},
    '{REQ_PUSH,     1'b1, 32'shFFFFFFFF,  1'b0, NO_RESULT},
    '{REQ_SUB,      1'b1, 32'sh7FFFFFFF,  1'b0, NO_RESULT},
    '{REQ_SUB,      1'b1, 32'sd1,         1'b0, NO_RESULT},
    '{REQ_ADD,      1'b1, 32'sh7FFFFFFF,  1'b0, NO_RESULT}
  };

  // Stack calculator state mirrored on the bench side
  logic [VALUE_W-1:0]        calc_stack [STACK_N];
  logic [DEPTH_W-1:0]        calc_sp;
  logic signed [VALUE_W-1:0] calc_answer;
  bit                        calc_fault;

  outcome_t pending_results [$];
  bit       steady = 1'b0;
  int       items_done = 0;
  int       items_ignored = 0;
  int       results_checked = 0;
  int       error_results = 0;
  int       mismatches = 0;
  int       deepest = 0;

  function automatic void calc_push(input logic signed [63:0] v);
    if (calc_sp >= STACK_N) begin
      calc_fault = 1'b1;
    end else begin
      calc_stack[calc_sp] = v[VALUE_W-1:0];
      calc_sp++;
    end
  endfunction

  // Popping an empty stack yields one and flags the fault
  function automatic logic [VALUE_W-1:0] calc_pop();
    if (calc_sp == 0) begin
      calc_fault = 1'b1;
      return 32'd1;
    end
    calc_sp--;
    return calc_stack[calc_sp];
  endfunction

  function automatic void calc_restart(input logic [VALUE_W-1:0] v);
    calc_sp = (v == 0) ? 9'd0 : 9'd1;
    calc_stack[0] = v;
  endfunction

  function automatic outcome_t calc_step(input logic [REQ_W-1:0] rq, input logic cn,
                                         input logic signed [VALUE_W-1:0] nv);
    logic signed [63:0] a;
    logic signed [63:0] b;
    outcome_t r;
    calc_fault = 1'b0;
    r.err = 1'b0;
    if (rq == REQ_CLEAR) begin
      calc_restart('0);
    end else if (rq <= REQ_DIV) begin
      if (rq != REQ_PUSH) calc_answer = calc_pop();
      if (cn) calc_push(nv);
      if (rq != REQ_PUSH) begin
        a = calc_answer;
        b = $signed(calc_pop());
        case (rq)
          REQ_ADD: calc_push(a + b);
          REQ_SUB: calc_push(a - b);
          REQ_MUL: calc_push((a * b) / DECIMAL_SCALE);
          default: begin
            if (b == 0) calc_fault = 1'b1;
            else calc_push((a * DECIMAL_SCALE) / b);
          end
        endcase
      end
      // Any fault restarts the stack from the last answer
      if (calc_fault) begin
        calc_restart(calc_answer);
        r.err = 1'b1;
      end
    end
    r.top = (calc_sp == 0) ? '0 : calc_stack[calc_sp - 1];
    r.depth = calc_sp;
    return r;
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_number();
    logic signed [VALUE_W-1:0] v;
    case ($urandom_range(9))
      0: v = '0;
      1: begin
        case ($urandom_range(5))
          0: v = 32'sh7FFFFFFF;
          1: v = 32'sh80000000;
          2: v = -32'sd1;
          3: v = 32'sd1;
          4: v = 32'sd1000;
          default: v = -32'sd1000;
        endcase
      end
      2, 3: v = $urandom;
      default: v = $signed($urandom_range(200000)) - 32'sd100000;
    endcase
    return v;
  endfunction

  // Offer one item, hold it until taken, then queue its expected result
  task automatic send_item(input logic [REQ_W-1:0] rq, input logic cn,
                           input logic signed [VALUE_W-1:0] nv, input logic known,
                           input outcome_t want);
    outcome_t predicted;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    req_type <= rq;
    carries_number <= cn;
    number <= nv;
    @(posedge clk);
    while (full) @(posedge clk);
    predicted = calc_step(rq, cn, nv);
    pending_results.push_back(known ? want : predicted);
    if (rq > REQ_CLEAR || (rq == REQ_PUSH && !cn)) items_ignored++;
    else items_done++;
    if (calc_sp > deepest) deepest = calc_sp;
  endtask

  // Fill the stack to the top and push once more to overflow it
  task automatic fill_stack(input bit zero_answer);
    if (zero_answer) begin
      // leave a zero last answer so the overflow empties the stack
      send_item(REQ_CLEAR, 1'b0, '0, 1'b0, NO_RESULT);
      send_item(REQ_PUSH, 1'b1, '0, 1'b0, NO_RESULT);
      send_item(REQ_PUSH, 1'b1, '0, 1'b0, NO_RESULT);
      send_item(REQ_ADD, 1'b0, '0, 1'b0, NO_RESULT);
    end
    while (calc_sp < STACK_N) send_item(REQ_PUSH, 1'b1, pick_number(), 1'b0, NO_RESULT);
    send_item(REQ_PUSH, 1'b1, pick_number(), 1'b0, NO_RESULT);
  endtask

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  task automatic check_result();
    outcome_t want;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result top %0d depth %0d error %0b",
                                top_value, stack_depth, error));
    end else begin
      want = pending_results.pop_front();
      if (top_value !== want.top)
        report_mismatch($sformatf("result %0d top_value %0d, predicted %0d",
                                  results_checked, top_value, want.top));
      if (stack_depth !== want.depth)
        report_mismatch($sformatf("result %0d stack_depth %0d, predicted %0d",
                                  results_checked, stack_depth, want.depth));
      if (error !== want.err)
        report_mismatch($sformatf("result %0d error %0b, predicted %0b",
                                  results_checked, error, want.err));
    end
    results_checked++;
    if (error) error_results++;
  endtask

  // Result side: take results with random stalls
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) check_result();
      if (rst) pop <= 1'b0;
      else pop <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Stop the run if neither side moves for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Stimulus: directed rows, then random traffic with two stack fills
  initial begin
    int pick;
    bit fill_a_done;
    bit fill_b_done;
    logic [REQ_W-1:0] rq;
    fill_a_done = 1'b0;
    fill_b_done = 1'b0;
    calc_sp = '0;
    calc_answer = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      send_item(plan[i].rq, plan[i].cn, plan[i].nv, plan[i].known, plan[i].want);
    end

    while (items_done + items_ignored < ITEM_TARGET) begin
      if (!fill_a_done && items_done >= 120) begin
        fill_a_done = 1'b1;
        fill_stack(1'b0);
      end else if (!fill_b_done && items_done >= 520) begin
        fill_b_done = 1'b1;
        fill_stack(1'b1);
      end else begin
        steady = (items_done >= 400 && items_done < 500);
        pick = $urandom_range(99);
        if (pick < 40) begin
          send_item(REQ_PUSH, 1'b1, pick_number(), 1'b0, NO_RESULT);
        end else if (pick < 83) begin
          rq = REQ_W'($urandom_range(REQ_DIV, REQ_ADD));
          send_item(rq, $urandom_range(99) < 70, pick_number(), 1'b0, NO_RESULT);
        end else if (pick < 88) begin
          send_item(REQ_CLEAR, 1'($urandom_range(1)), $urandom, 1'b0, NO_RESULT);
        end else if (pick < 93) begin
          send_item(REQ_PUSH, 1'b0, $urandom, 1'b0, NO_RESULT);
        end else begin
          rq = $urandom_range(1) ? REQ_UNUSED_B : REQ_UNUSED_A;
          send_item(rq, 1'($urandom_range(1)), $urandom, 1'b0, NO_RESULT);
        end
      end
    end
    steady = 1'b0;
    push <= 1'b0;

    // Drain outstanding results, then watch for strays
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d working items and %0d ignored ones, stack reached depth %0d",
             items_done, items_ignored, deepest);
    $display("checked %0d results, %0d of them flagged an error, %0d mismatches",
             results_checked, error_results, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/rpnfx_pkg.sv
sv/rpnfx_front.sv
sv/rpnfx_div.sv
sv/rpnfx_back.sv
sv/rpn_fixed_point_stack_alu.sv
test/tb.sv
